// File: src/epd_pkg.sv
// shared types and constants for the eeg packet deframer
// no dependencies; imported by every module of the block
package epd_pkg;

    localparam int unsigned CHANNELS_DEF = 8;
    localparam int unsigned STORE_DEPTH  = 25;
    localparam int unsigned IDX_W        = $clog2(STORE_DEPTH);

    localparam logic [7:0] HEADER_BYTE = 8'hA0;
    localparam logic [7:0] FOOTER_MASK = 8'hF0;
    localparam logic [7:0] FOOTER_MARK = 8'hC0;
    localparam logic [7:0] SN_ODD_MASK = 8'h01;
    localparam logic [5:0] POS_IDLE    = 6'd0;
    localparam logic [5:0] POS_FIRST   = 6'd1;
    localparam logic [5:0] FOOTER_POS  = 6'd32;

    typedef logic signed [23:0] t_sample;

    typedef struct packed {
        logic       err;
        logic       drop;
        logic [7:0] sn;
    } t_pkt_ctl;

endpackage

// File: src/epd_framer.sv
// byte framer: tracks packet position, stores payload, checks footer and sequence
// depends on epd_pkg
module epd_framer
    import epd_pkg::*;
#(
    parameter int unsigned CHANNELS = CHANNELS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_byte,
    output logic       o_at_footer,
    output logic       o_load,
    output t_pkt_ctl   o_ctl,
    output t_sample    o_vals [CHANNELS]
);

    logic [5:0]       r_pos;
    logic [5:0]       n_pos;
    logic [7:0]       r_store [STORE_DEPTH];
    logic [7:0]       r_prev_sn;
    logic             r_first;
    logic [IDX_W-1:0] w_idx;
    logic             w_idle;
    logic             w_good;

    assign w_idle      = (r_pos == POS_IDLE) || (r_pos > FOOTER_POS);
    assign o_at_footer = (r_pos == FOOTER_POS);
    assign w_idx       = IDX_W'(r_pos - POS_FIRST);
    assign w_good      = (i_byte & FOOTER_MASK) == FOOTER_MARK;
    assign o_load      = i_take && o_at_footer;

    always_comb begin
        if (w_idle) begin
            n_pos = (i_byte == HEADER_BYTE) ? POS_FIRST : POS_IDLE;
        end else if (o_at_footer) begin
            n_pos = POS_IDLE;
        end else begin
            n_pos = r_pos + 6'd1;
        end
    end

    always_comb begin
        o_ctl.err  = !w_good;
        o_ctl.sn   = r_store[0];
        o_ctl.drop = w_good && !r_first && (r_store[0] != (r_prev_sn + 8'd1));
    end

    for (genvar g = 0; g < CHANNELS; g++) begin : g_val
        assign o_vals[g] = {r_store[1+3*g], r_store[2+3*g], r_store[3+3*g]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= POS_IDLE;
            r_prev_sn <= '0;
            r_first   <= 1'b1;
        end else if (i_take) begin
            r_pos <= n_pos;
            if (o_at_footer) begin
                if (w_good) begin
                    r_first   <= 1'b0;
                    r_prev_sn <= r_store[0];
                end else begin
                    r_first <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take && !w_idle && !o_at_footer && (r_pos <= 6'(STORE_DEPTH))) begin
            r_store[w_idx] <= i_byte;
        end
    end

endmodule

// File: src/epd_emitter.sv
// result buffer: holds one framed packet and hands out its words one by one
// depends on epd_pkg
module epd_emitter
    import epd_pkg::*;
#(
    parameter int unsigned CHANNELS = CHANNELS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_pkt_ctl   i_ctl,
    input  t_sample    i_vals [CHANNELS],
    input  logic       i_out_stall,
    output logic       o_busy,
    output logic       o_out_valid,
    output logic [3:0] o_channel_index,
    output t_sample    o_sample_value,
    output logic [7:0] o_sample_number,
    output logic       o_dropped_flag,
    output logic       o_footer_error,
    output logic       o_last_of_packet
);

    localparam int unsigned CNT_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic             r_pend;
    logic [CNT_W-1:0] r_cnt;
    t_pkt_ctl         r_ctl;
    t_sample          r_vals [CHANNELS];
    logic             w_take;
    logic             w_last;

    assign w_take = r_pend && !i_out_stall;
    assign w_last = r_ctl.err || (32'(r_cnt) == CHANNELS - 1);

    assign o_busy           = r_pend;
    assign o_out_valid      = r_pend;
    assign o_channel_index  = r_ctl.err ? 4'd0
                            : 4'({((r_ctl.sn & SN_ODD_MASK) != 8'd0), 3'(r_cnt)});
    assign o_sample_value   = r_ctl.err ? '0 : r_vals[r_cnt];
    assign o_sample_number  = r_ctl.sn;
    assign o_dropped_flag   = r_ctl.drop && !r_ctl.err;
    assign o_footer_error   = r_ctl.err;
    assign o_last_of_packet = w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_cnt  <= '0;
        end else if (i_load) begin
            r_pend <= 1'b1;
            r_cnt  <= '0;
        end else if (w_take) begin
            if (w_last) begin
                r_pend <= 1'b0;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ctl  <= i_ctl;
            r_vals <= i_vals;
        end
    end

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> !r_pend)
        else $error("packet loaded while results still pending");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (32'(r_cnt) < CHANNELS))
        else $error("word counter beyond channel count");

    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend && r_ctl.err) |-> (r_cnt == '0))
        else $error("error packet emitting more than one word");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && w_last && !i_load) |=> (!r_pend || $past(i_load)))
        else $error("results continue past last word");

endmodule

// File: src/eeg_packet_deframer.sv
// Top level of the eeg packet deframer: one serial byte per input word, 33-byte
// packets (header 0xA0, sample number, eight 24-bit big-endian counts, six aux
// bytes, footer 0xCx), up to eight result words per packet. Depends on epd_pkg,
// epd_framer and epd_emitter.
//
// A valid byte is taken every cycle. Only the footer byte can be held off: it waits
// while the result buffer still holds words of the previous packet, since the
// single buffer takes one packet at a time. A good footer yields CHANNELS result
// words, a bad one a single error word; the first result is offered the cycle
// after the footer is taken, then one word per cycle the output is not stalled.
module eeg_packet_deframer
    import epd_pkg::*;
#(
    parameter int unsigned CHANNELS = CHANNELS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [3:0] o_channel_index,
    output t_sample    o_sample_value,
    output logic [7:0] o_sample_number,
    output logic       o_dropped_flag,
    output logic       o_footer_error,
    output logic       o_last_of_packet
);

    logic     w_take;
    logic     w_at_footer;
    logic     w_load;
    logic     w_busy;
    t_pkt_ctl w_ctl;
    t_sample  w_vals [CHANNELS];

    assign o_in_stall = w_at_footer && w_busy;
    assign w_take     = i_in_valid && !o_in_stall;

    epd_framer #(
        .CHANNELS (CHANNELS)
    ) u_framer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (w_take),
        .i_byte      (i_rx_byte),
        .o_at_footer (w_at_footer),
        .o_load      (w_load),
        .o_ctl       (w_ctl),
        .o_vals      (w_vals)
    );

    epd_emitter #(
        .CHANNELS (CHANNELS)
    ) u_emitter (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_load           (w_load),
        .i_ctl            (w_ctl),
        .i_vals           (w_vals),
        .i_out_stall      (i_out_stall),
        .o_busy           (w_busy),
        .o_out_valid      (o_out_valid),
        .o_channel_index  (o_channel_index),
        .o_sample_value   (o_sample_value),
        .o_sample_number  (o_sample_number),
        .o_dropped_flag   (o_dropped_flag),
        .o_footer_error   (o_footer_error),
        .o_last_of_packet (o_last_of_packet)
    );

endmodule

// File: bench/eeg_deframe_checker.sv
// checker for the eeg packet deframer: watches the byte and result channels,
// keeps its own deframing state and compares every result word in order
// depends on epd_pkg for the sample type and the framing constants
module eeg_deframe_checker
    import epd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [7:0] i_rx_byte,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [3:0] i_channel_index,
    input  t_sample    i_sample_value,
    input  logic [7:0] i_sample_number,
    input  logic       i_dropped_flag,
    input  logic       i_footer_error,
    input  logic       i_last_of_packet,
    output int         o_mismatches,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [3:0] chan;
        t_sample    value;
        logic [7:0] sn;
        logic       drop;
        logic       err;
        logic       last;
    } t_deframed_word;

    t_deframed_word channel_words [$];
    logic [5:0]     frame_pos   = POS_IDLE;
    logic [7:0]     frame_store [STORE_DEPTH];
    logic [7:0]     last_sn     = '0;
    logic           seq_restart = 1'b1;
    int             mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    task automatic flag_field(input string fld, input longint want_v, input longint got_v);
        $display("%0t mismatch in %s: expected %0d, got %0d", $time, fld, want_v, got_v);
        mismatch_count++;
    endtask

    task automatic deframe_byte(input logic [7:0] b);
        t_deframed_word w;
        logic [5:0]     pos;
        logic [7:0]     sn;
        logic           drop;
        int             j;
        pos = frame_pos;
        if (pos == POS_IDLE || pos > FOOTER_POS) begin
            frame_pos = (b == HEADER_BYTE) ? POS_FIRST : POS_IDLE;
        end else if (pos < FOOTER_POS) begin
            j = int'(pos) - 1;
            if (j < STORE_DEPTH) frame_store[j] = b;
            frame_pos = pos + 6'd1;
        end else begin
            frame_pos = POS_IDLE;
            sn = frame_store[0];
            if ((b & FOOTER_MASK) != FOOTER_MARK) begin
                seq_restart = 1'b1;
                w = '0;
                w.sn = sn;
                w.err = 1'b1;
                w.last = 1'b1;
                channel_words.push_back(w);
            end else begin
                drop = !seq_restart && (sn != 8'(last_sn + 8'd1));
                seq_restart = 1'b0;
                last_sn = sn;
                for (int i = 0; i < CHANNELS_DEF && i < 8; i++) begin
                    j = 1 + 3 * i;
                    w.chan  = 4'(((sn & SN_ODD_MASK) != 0 ? 8 : 0) + i);
                    w.value = {frame_store[j], frame_store[j + 1], frame_store[j + 2]};
                    w.sn    = sn;
                    w.drop  = drop;
                    w.err   = 1'b0;
                    w.last  = (i == CHANNELS_DEF - 1);
                    channel_words.push_back(w);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_deframed_word got;
        t_deframed_word want;
        if (!i_rst_n) begin
            frame_pos = POS_IDLE;
            last_sn = '0;
            seq_restart = 1'b1;
            channel_words.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got.chan  = i_channel_index;
                got.value = i_sample_value;
                got.sn    = i_sample_number;
                got.drop  = i_dropped_flag;
                got.err   = i_footer_error;
                got.last  = i_last_of_packet;
                if (channel_words.size() == 0) begin
                    $display("%0t extra word: expected none, got %0d/%0d/%0d/%0b/%0b/%0b",
                             $time, got.chan, got.value, got.sn, got.drop, got.err,
                             got.last);
                    mismatch_count++;
                end else begin
                    want = channel_words.pop_front();
                    if (got.chan !== want.chan)
                        flag_field("channel_index", want.chan, got.chan);
                    if (got.value !== want.value)
                        flag_field("sample_value", want.value, got.value);
                    if (got.sn !== want.sn)
                        flag_field("sample_number", want.sn, got.sn);
                    if (got.drop !== want.drop)
                        flag_field("dropped_flag", want.drop, got.drop);
                    if (got.err !== want.err)
                        flag_field("footer_error", want.err, got.err);
                    if (got.last !== want.last)
                        flag_field("last_of_packet", want.last, got.last);
                end
            end
            if (i_in_valid && !i_in_stall) deframe_byte(i_rx_byte);
        end
        o_pending <= channel_words.size();
    end

endmodule

// File: bench/tb.sv
// top of the deframer bench: clock, reset, byte stimulus and result stalling
// depends on epd_pkg, eeg_packet_deframer and eeg_deframe_checker
module tb;
    import epd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic [7:0] rx_byte   = '0;
    logic       out_stall = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic [3:0] channel_index;
    t_sample    sample_value;
    logic [7:0] sample_number;
    logic       dropped_flag;
    logic       footer_error;
    logic       last_of_packet;
    int         mismatches;
    int         pending;

    int         snd_idle_pct  = 0;
    int         rcv_stall_pct = 0;
    int         cycle_count   = 0;
    logic [7:0] next_sn       = '0;
    logic [23:0] pkt_counts [CHANNELS_DEF];

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    eeg_packet_deframer DUT (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_rx_byte        (rx_byte),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_channel_index  (channel_index),
        .o_sample_value   (sample_value),
        .o_sample_number  (sample_number),
        .o_dropped_flag   (dropped_flag),
        .o_footer_error   (footer_error),
        .o_last_of_packet (last_of_packet)
    );

    eeg_deframe_checker checker_i (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_rx_byte        (rx_byte),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_channel_index  (channel_index),
        .i_sample_value   (sample_value),
        .i_sample_number  (sample_number),
        .i_dropped_flag   (dropped_flag),
        .i_footer_error   (footer_error),
        .i_last_of_packet (last_of_packet),
        .o_mismatches     (mismatches),
        .o_pending        (pending)
    );

    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < rcv_stall_pct);
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < snd_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(negedge clk);
        while (in_stall) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic send_packet(input logic [7:0] sn, input logic [7:0] footer);
        send_byte(HEADER_BYTE);
        send_byte(sn);
        foreach (pkt_counts[i]) begin
            send_byte(pkt_counts[i][23:16]);
            send_byte(pkt_counts[i][15:8]);
            send_byte(pkt_counts[i][7:0]);
        end
        repeat (6) send_byte(8'($urandom));
        send_byte(footer);
    endtask

    function automatic logic [23:0] rand_count();
        case ($urandom_range(7))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'h000000;
            3: return 24'hFFFFFF;
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic run_random(input int quota);
        int         done_bytes;
        int         pick;
        int         len;
        logic [7:0] sn;
        logic [7:0] foot;
        done_bytes = 0;
        while (done_bytes < quota) begin
            pick = $urandom_range(99);
            if (pick < 75) begin
                sn = ($urandom_range(99) < 80) ? next_sn : 8'($urandom);
                foreach (pkt_counts[i]) pkt_counts[i] = rand_count();
                if ($urandom_range(99) < 85) begin
                    foot = FOOTER_MARK | 8'($urandom_range(15));
                end else begin
                    do foot = 8'($urandom); while ((foot & FOOTER_MASK) == FOOTER_MARK);
                end
                send_packet(sn, foot);
                next_sn = sn + 8'd1;
                done_bytes += 33;
            end else if (pick < 87) begin
                len = $urandom_range(4, 1);
                repeat (len) send_byte(8'($urandom));
                done_bytes += len;
            end else begin
                // truncated frame, the following bytes land in its payload
                len = $urandom_range(31, 1);
                send_byte(HEADER_BYTE);
                repeat (len) send_byte(8'($urandom));
                done_bytes += len + 1;
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hA1);
        pkt_counts = '{24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF,
                       24'h000001, 24'hFFFFFE, 24'h800001, 24'h7FFFFE};
        send_packet(8'd0, 8'hC0);
        pkt_counts = '{24'h5A5A5A, 24'hA5A5A5, 24'h0F0F0F, 24'hF0F0F0,
                       24'h123456, 24'hEDCBA9, 24'h00FF00, 24'hFF00FF};
        send_packet(8'd1, 8'hCF);
        // skipped sample number
        send_packet(8'd3, 8'hC5);
        send_packet(8'd4, 8'hD0);
        // restart after a bad footer, odd sample number
        send_packet(8'd255, 8'hC3);
        send_packet(8'd0, 8'hCA);
        send_packet(8'd1, 8'h0C);
        next_sn = 8'd2;

        run_random(24);
        snd_idle_pct = 67;
        run_random(24);
        snd_idle_pct  = 0;
        rcv_stall_pct = 67;
        run_random(24);
        snd_idle_pct  = 27;
        rcv_stall_pct = 27;
        run_random(24);
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (16) @(posedge clk);
        if (mismatches == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
